// ===== rtl/pmrt_pkg.sv =====
package pmrt_pkg;

  // Default depth of the queue behind the classifier and of the result queue.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Delimiter octets.
  localparam logic [7:0] PREAMBLE_OCTET = 8'h55;
  localparam logic [7:0] CODE_EXPRESS   = 8'hd5;
  localparam logic [7:0] CODE_VERIFY    = 8'h07;
  localparam logic [7:0] CODE_RESPOND   = 8'h19;

  // The start codes double as fragment count codes; index 0..3 in both tables.
  localparam logic [7:0] START_CODES [4] = '{8'he6, 8'h4c, 8'h7f, 8'hb3};
  localparam logic [7:0] CONT_CODES  [4] = '{8'h61, 8'h52, 8'h9e, 8'h2a};

  // The merge CRC is the plain CRC with its upper half inverted.
  localparam logic [31:0] MERGE_CRC_MASK = 32'hffff0000;

  // Fragment count stored after a cleared context.
  localparam logic [1:0] LAST_COUNT_RESET = 2'd3;

  typedef enum logic [2:0] {
    KIND_EXPRESS = 3'd0,
    KIND_VERIFY  = 3'd1,
    KIND_RESPOND = 3'd2,
    KIND_START   = 3'd3,
    KIND_CONT    = 3'd4,
    KIND_INVALID = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    CRC_PLAIN = 2'd0,
    CRC_MERGE = 2'd1,
    CRC_BAD   = 2'd2
  } crc_t;

  typedef enum logic [2:0] {
    DISP_IGNORE  = 3'd0,
    DISP_DELIVER = 3'd1,
    DISP_START   = 3'd2,
    DISP_APPEND  = 3'd3,
    DISP_FINAL   = 3'd4,
    DISP_REJECT  = 3'd5
  } disp_t;

  // Result of looking a code up in one of the four-entry code tables.
  typedef struct packed {
    logic       hit;
    logic [1:0] idx;
  } code_hit_t;

  // A classified word, as handed from the front end to the back end.
  typedef struct packed {
    kind_t       kind;
    crc_t        crc;
    logic [1:0]  start_idx;
    logic [1:0]  cont_idx;
    logic [15:0] len;
  } class_t;

  // A finished result word.
  typedef struct packed {
    kind_t       kind;
    crc_t        crc;
    disp_t       disp;
    logic [15:0] offset;
    logic [15:0] assembled;
  } result_t;

  // Finds a code in a four-entry table; the first match wins.
  function automatic code_hit_t code_lookup(input logic [7:0] code, input logic [7:0] tab [4]);
    code_hit_t r;
    r = '0;
    for (int i = 3; i >= 0; i--) begin
      if (tab[i] == code) begin
        r.hit = 1'b1;
        r.idx = 2'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/pmrt_fifo.sv =====
module pmrt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage is written in place; it needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/pmrt_front.sv =====
module pmrt_front (
  input  logic [7:0]           lead_octet,
  input  logic [7:0]           smd_octet,
  input  logic [15:0]          data_length,
  input  logic [31:0]          computed_crc,
  input  logic [31:0]          rx_crc,
  output pmrt_pkg::class_t     cls
);

  import pmrt_pkg::*;

  code_hit_t start_hit;
  code_hit_t cont_hit;
  crc_t      crc;
  kind_t     kind;

  assign start_hit = code_lookup(smd_octet, START_CODES);
  assign cont_hit  = code_lookup(lead_octet, CONT_CODES);

  // Sort the CRC: plain match first, then the merge-modified form.
  always_comb begin
    priority if (rx_crc == computed_crc) begin
      crc = CRC_PLAIN;
    end else if (rx_crc == (computed_crc ^ MERGE_CRC_MASK)) begin
      crc = CRC_MERGE;
    end else begin
      crc = CRC_BAD;
    end
  end

  // Sort the packet kind from the two delimiter octets.
  always_comb begin
    if (lead_octet == PREAMBLE_OCTET) begin
      priority if (start_hit.hit) begin
        kind = KIND_START;
      end else if (smd_octet == CODE_VERIFY) begin
        kind = KIND_VERIFY;
      end else if (smd_octet == CODE_RESPOND) begin
        kind = KIND_RESPOND;
      end else if (smd_octet == CODE_EXPRESS) begin
        kind = KIND_EXPRESS;
      end else begin
        kind = KIND_INVALID;
      end
    end else if (cont_hit.hit && start_hit.hit) begin
      kind = KIND_CONT;
    end else begin
      kind = KIND_INVALID;
    end
  end

  assign cls = '{kind: kind, crc: crc, start_idx: start_hit.idx,
                 cont_idx: cont_hit.idx, len: data_length};

endmodule

// ===== rtl/pmrt_back.sv =====
module pmrt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  pmrt_pkg::class_t  cls,
  output pmrt_pkg::result_t res
);

  import pmrt_pkg::*;

  logic        ctx_active;
  logic [1:0]  exp_smd;
  logic [1:0]  last_count;
  logic [15:0] acc_len;

  logic        ctx_active_next;
  logic [1:0]  exp_smd_next;
  logic [1:0]  last_count_next;
  logic [15:0] acc_len_next;

  logic        match;
  logic [16:0] sum;
  logic [15:0] sat_sum;

  // A continuation must follow the open context with the next fragment count.
  assign match   = ctx_active && (exp_smd == cls.cont_idx) &&
                   ((last_count + 2'd1) == cls.start_idx);
  assign sum     = {1'b0, acc_len} + {1'b0, cls.len};
  assign sat_sum = sum[16] ? 16'hffff : sum[15:0];

  // Disposition and the next context for the word at the head of the queue.
  always_comb begin
    ctx_active_next = ctx_active;
    exp_smd_next    = exp_smd;
    last_count_next = last_count;
    acc_len_next    = acc_len;
    res             = '{kind: cls.kind, crc: cls.crc, disp: DISP_IGNORE,
                        offset: 16'd0, assembled: 16'd0};
    unique case (cls.kind)
      KIND_EXPRESS: begin
        if (cls.crc == CRC_PLAIN) begin
          res.disp      = DISP_DELIVER;
          res.assembled = cls.len;
        end else begin
          res.disp = DISP_REJECT;
        end
      end
      KIND_START: begin
        ctx_active_next = 1'b0;
        exp_smd_next    = 2'd0;
        last_count_next = LAST_COUNT_RESET;
        acc_len_next    = 16'd0;
        if (cls.crc == CRC_PLAIN) begin
          res.disp      = DISP_DELIVER;
          res.assembled = cls.len;
        end else if (cls.crc == CRC_MERGE) begin
          ctx_active_next = 1'b1;
          exp_smd_next    = cls.start_idx;
          acc_len_next    = cls.len;
          res.disp        = DISP_START;
          res.assembled   = cls.len;
        end else begin
          res.disp = DISP_REJECT;
        end
      end
      KIND_CONT: begin
        if (match && cls.crc == CRC_MERGE) begin
          acc_len_next    = sat_sum;
          last_count_next = cls.start_idx;
          res.disp        = DISP_APPEND;
          res.offset      = acc_len;
          res.assembled   = sat_sum;
        end else begin
          ctx_active_next = 1'b0;
          exp_smd_next    = 2'd0;
          last_count_next = LAST_COUNT_RESET;
          acc_len_next    = 16'd0;
          if (match) begin
            res.disp      = DISP_FINAL;
            res.offset    = acc_len;
            res.assembled = sat_sum;
          end else begin
            res.disp = DISP_REJECT;
          end
        end
      end
      KIND_INVALID: begin
        res.disp = DISP_REJECT;
      end
      default: begin
        res.disp = DISP_IGNORE;
      end
    endcase
  end

  // Reassembly context, updated once per word taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctx_active <= 1'b0;
      exp_smd    <= 2'd0;
      last_count <= LAST_COUNT_RESET;
      acc_len    <= 16'd0;
    end else if (take) begin
      ctx_active <= ctx_active_next;
      exp_smd    <= exp_smd_next;
      last_count <= last_count_next;
      acc_len    <= acc_len_next;
    end
  end

endmodule

// ===== rtl/preemption_mpacket_reassembly_tracker_unit.sv =====
// Receive-side tracker for preempted (mPacket) traffic. Each word pushed in
// summarises one mPacket: its two delimiter octets, its data length and the
// computed and received CRCs. Exactly one result word comes out per input
// word, in order: the packet kind, the CRC class, what to do with the data
// and, for fragments, the byte offset and the saturating assembled length.
// Both sides behave as queues (push/full, pop/empty). The block takes one
// word every clock cycle while full is low; an accepted word is held in the
// classifier queue, is then written into the result queue and is then shown
// on the result ports, one register stage in each of the two queues.
// The sustained rate is set by the single context update in the back end.
// There is no start-up pass after reset.
module preemption_mpacket_reassembly_tracker_unit #(
  parameter int unsigned QUEUE_DEPTH = pmrt_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  lead_octet,
  input  logic [7:0]  smd_octet,
  input  logic [15:0] data_length,
  input  logic [31:0] computed_crc,
  input  logic [31:0] rx_crc,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  packet_kind,
  output logic [1:0]  crc_status,
  output logic [2:0]  disposition,
  output logic [15:0] fragment_offset,
  output logic [15:0] assembled_length
);

  import pmrt_pkg::*;

  localparam int unsigned CLASS_W  = $bits(class_t);
  localparam int unsigned RESULT_W = $bits(result_t);

  class_t              cls_in;
  logic [CLASS_W-1:0]  cls_q_raw;
  class_t              cls_q;
  logic                mid_empty;
  logic                out_full;
  logic                take;
  result_t             res;
  logic [RESULT_W-1:0] res_q_raw;
  result_t             res_q;

  // Front end: classify the incoming word.
  pmrt_front u_front (
    .lead_octet   (lead_octet),
    .smd_octet    (smd_octet),
    .data_length  (data_length),
    .computed_crc (computed_crc),
    .rx_crc       (rx_crc),
    .cls          (cls_in)
  );

  // Queue between the classifier and the context logic.
  pmrt_fifo #(
    .WIDTH (CLASS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .wdata (cls_in),
    .pop   (take),
    .empty (mid_empty),
    .rdata (cls_q_raw)
  );

  assign cls_q = class_t'(cls_q_raw);
  assign take  = !mid_empty && !out_full;

  // Back end: apply the word to the reassembly context.
  pmrt_back u_back (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .cls  (cls_q),
    .res  (res)
  );

  // Result queue towards the consumer.
  pmrt_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (take),
    .full  (out_full),
    .wdata (res),
    .pop   (pop),
    .empty (empty),
    .rdata (res_q_raw)
  );

  assign res_q            = result_t'(res_q_raw);
  assign packet_kind      = res_q.kind;
  assign crc_status       = res_q.crc;
  assign disposition      = res_q.disp;
  assign fragment_offset  = res_q.offset;
  assign assembled_length = res_q.assembled;

endmodule

// ===== verif/tb_preemption_mpacket_reassembly_tracker_unit.sv =====
`timescale 1ns / 100ps

module tb_preemption_mpacket_reassembly_tracker_unit;
  import pmrt_pkg::*;

  localparam int TOTAL_WORDS  = 1550;
  localparam int LIMIT_CYCLES = 100000;
  localparam int GAP_PERCENT  = 28;

  // One expected result word, typed with the package enums.
  typedef struct {
    kind_t       kind;
    crc_t        crc;
    disp_t       disp;
    logic [15:0] offset;
    logic [15:0] assembled;
  } verdict_t;

  // One row of the directed stimulus; want is only used when typed is set.
  typedef struct {
    logic [7:0]  lead;
    logic [7:0]  smd;
    logic [15:0] len;
    logic [31:0] calc;
    logic [31:0] recv;
    bit          typed;
    verdict_t    want;
  } probe_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  lead_octet;
  logic [7:0]  smd_octet;
  logic [15:0] data_length;
  logic [31:0] computed_crc;
  logic [31:0] rx_crc;
  logic        empty;
  logic        pop;
  logic [2:0]  packet_kind;
  logic [1:0]  crc_status;
  logic [2:0]  disposition;
  logic [15:0] fragment_offset;
  logic [15:0] assembled_length;

  preemption_mpacket_reassembly_tracker_unit dut (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .lead_octet       (lead_octet),
    .smd_octet        (smd_octet),
    .data_length      (data_length),
    .computed_crc     (computed_crc),
    .rx_crc           (rx_crc),
    .empty            (empty),
    .pop              (pop),
    .packet_kind      (packet_kind),
    .crc_status       (crc_status),
    .disposition      (disposition),
    .fragment_offset  (fragment_offset),
    .assembled_length (assembled_length)
  );

  // Shadow of the reassembly context.
  bit          ctx_active;
  logic [1:0]  ctx_cont_slot;
  logic [1:0]  ctx_last_count;
  logic [15:0] ctx_length;

  verdict_t    pending_results [$];
  probe_t      directed_rows [$];
  verdict_t    row_expect;
  verdict_t    forecast;
  verdict_t    oldest;
  bit          row_typed;
  bit          gaps_on;
  int          words_in;
  int          words_sent;
  int          mismatch_count;
  int          cycle_count;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Returns the slot of a code in the start or continuation table, or -1.
  function automatic int code_slot(input logic [7:0] code, input bit cont_side);
    int slot;
    slot = -1;
    for (int i = 3; i >= 0; i--) begin
      if ((cont_side ? CONT_CODES[i] : START_CODES[i]) == code) slot = i;
    end
    return slot;
  endfunction

  function automatic void clear_context();
    ctx_active     = 1'b0;
    ctx_cont_slot  = 2'd0;
    ctx_last_count = LAST_COUNT_RESET;
    ctx_length     = 16'd0;
  endfunction

  // Classifies one word, updates the shadow context and returns its result.
  function automatic verdict_t predict_disposition(input logic [7:0] lead, input logic [7:0] smd,
                                                   input logic [15:0] len,
                                                   input logic [31:0] calc,
                                                   input logic [31:0] recv);
    verdict_t   v;
    int         si;
    int         ci;
    logic [16:0] sum;
    logic [15:0] capped;
    logic [1:0]  next_count;
    bit          chained;
    v = '{KIND_INVALID, CRC_BAD, DISP_IGNORE, 16'd0, 16'd0};
    si = code_slot(smd, 1'b0);
    ci = code_slot(lead, 1'b1);

    if (recv == calc) v.crc = CRC_PLAIN;
    else if (recv == (calc ^ MERGE_CRC_MASK)) v.crc = CRC_MERGE;
    else v.crc = CRC_BAD;

    if (lead == PREAMBLE_OCTET) begin
      if (si >= 0) v.kind = KIND_START;
      else if (smd == CODE_VERIFY) v.kind = KIND_VERIFY;
      else if (smd == CODE_RESPOND) v.kind = KIND_RESPOND;
      else if (smd == CODE_EXPRESS) v.kind = KIND_EXPRESS;
    end else if (ci >= 0 && si >= 0) begin
      v.kind = KIND_CONT;
    end

    sum = {1'b0, ctx_length} + {1'b0, len};
    capped = sum[16] ? 16'hffff : sum[15:0];
    next_count = ctx_last_count + 2'd1;

    case (v.kind)
      KIND_EXPRESS: begin
        if (v.crc == CRC_PLAIN) begin
          v.disp = DISP_DELIVER;
          v.assembled = len;
        end else begin
          v.disp = DISP_REJECT;
        end
      end
      KIND_START: begin
        if (v.crc == CRC_PLAIN) begin
          clear_context();
          v.disp = DISP_DELIVER;
          v.assembled = len;
        end else if (v.crc == CRC_MERGE) begin
          ctx_active     = 1'b1;
          ctx_cont_slot  = si[1:0];
          ctx_last_count = LAST_COUNT_RESET;
          ctx_length     = len;
          v.disp = DISP_START;
          v.assembled = len;
        end else begin
          clear_context();
          v.disp = DISP_REJECT;
        end
      end
      KIND_CONT: begin
        chained = ctx_active && ctx_cont_slot == ci[1:0] && next_count == si[1:0];
        if (!chained) begin
          clear_context();
          v.disp = DISP_REJECT;
        end else begin
          v.offset = ctx_length;
          v.assembled = capped;
          if (v.crc == CRC_MERGE) begin
            ctx_length     = capped;
            ctx_last_count = si[1:0];
            v.disp = DISP_APPEND;
          end else begin
            clear_context();
            v.disp = DISP_FINAL;
          end
        end
      end
      KIND_INVALID: v.disp = DISP_REJECT;
      default: v.disp = DISP_IGNORE;
    endcase
    return v;
  endfunction

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Input and result words are both taken at the rising edge.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
      $display("tb_preemption_mpacket_reassembly_tracker_unit NOT OK");
      $finish;
    end else if (rst) begin
      clear_context();
    end else begin
      if (push && !full) begin
        forecast = predict_disposition(lead_octet, smd_octet, data_length,
                                       computed_crc, rx_crc);
        pending_results.push_back(row_typed ? row_expect : forecast);
        words_in++;
      end
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word with nothing expected, actual kind %0d disp %0d",
                   $time, packet_kind, disposition);
          mismatch_count++;
        end else begin
          oldest = pending_results.pop_front();
          field_check("packet_kind", 32'(oldest.kind), 32'(packet_kind));
          field_check("crc_status", 32'(oldest.crc), 32'(crc_status));
          field_check("disposition", 32'(oldest.disp), 32'(disposition));
          field_check("fragment_offset", 32'(oldest.offset), 32'(fragment_offset));
          field_check("assembled_length", 32'(oldest.assembled), 32'(assembled_length));
        end
      end
    end
  end

  // The result side stalls at random while gaps are switched on.
  always @(negedge clk) begin
    pop = !(gaps_on && $urandom_range(99) < GAP_PERCENT);
  end

  // Drives one word at the falling edge and holds it until it is taken.
  task automatic put_word(input logic [7:0] lead, input logic [7:0] smd, input logic [15:0] len,
                          input logic [31:0] calc, input logic [31:0] recv,
                          input bit typed, input verdict_t want);
    int target;
    while (gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      push = 1'b0;
      @(negedge clk);
    end
    lead_octet   = lead;
    smd_octet    = smd;
    data_length  = len;
    computed_crc = calc;
    rx_crc       = recv;
    row_typed    = typed;
    row_expect   = want;
    push         = 1'b1;
    target       = words_in + 1;
    do @(negedge clk); while (words_in != target);
    words_sent++;
  endtask

  function automatic logic [31:0] recv_for(input logic [31:0] calc, input crc_t mode);
    logic [31:0] r;
    case (mode)
      CRC_PLAIN: r = calc;
      CRC_MERGE: r = calc ^ MERGE_CRC_MASK;
      default: begin
        r = $urandom;
        if (r == calc || r == (calc ^ MERGE_CRC_MASK)) r = calc ^ 32'h1;
      end
    endcase
    return r;
  endfunction

  // Mostly frame-sized lengths, now and then any length at all.
  function automatic logic [15:0] pick_len();
    if ($urandom_range(9) == 0) return 16'($urandom_range(65535));
    return 16'($urandom_range(1600));
  endfunction

  task automatic send_random(input logic [7:0] lead, input logic [7:0] smd, input crc_t mode);
    verdict_t unused;
    logic [31:0] calc;
    unused = '{KIND_INVALID, CRC_BAD, DISP_IGNORE, 16'd0, 16'd0};
    calc = $urandom;
    put_word(lead, smd, pick_len(), calc, recv_for(calc, mode), 1'b0, unused);
  endtask

  task automatic add_row(input logic [7:0] lead, input logic [7:0] smd, input logic [15:0] len,
                         input logic [31:0] calc, input logic [31:0] recv);
    directed_rows.push_back('{lead, smd, len, calc, recv, 1'b0,
                              '{KIND_INVALID, CRC_BAD, DISP_IGNORE, 16'd0, 16'd0}});
  endtask

  task automatic add_typed_row(input logic [7:0] lead, input logic [7:0] smd,
                               input logic [15:0] len, input logic [31:0] calc,
                               input logic [31:0] recv, input kind_t kind, input crc_t crc,
                               input disp_t disp, input logic [15:0] offset,
                               input logic [15:0] assembled);
    directed_rows.push_back('{lead, smd, len, calc, recv, 1'b1,
                              '{kind, crc, disp, offset, assembled}});
  endtask

  // A word that leaves the context alone: express, verify or respond.
  task automatic send_bystander();
    case ($urandom_range(2))
      0: send_random(PREAMBLE_OCTET, CODE_EXPRESS, crc_t'($urandom_range(2)));
      1: send_random(PREAMBLE_OCTET, CODE_VERIFY, crc_t'($urandom_range(2)));
      default: send_random(PREAMBLE_OCTET, CODE_RESPOND, crc_t'($urandom_range(2)));
    endcase
  endtask

  task automatic send_noise();
    case ($urandom_range(4))
      0: send_bystander();
      1: send_random(8'($urandom), 8'($urandom), crc_t'($urandom_range(2)));
      2: send_random(PREAMBLE_OCTET, START_CODES[2'($urandom_range(3))],
                     $urandom_range(1) ? CRC_PLAIN : CRC_BAD);
      3: send_random(CONT_CODES[2'($urandom_range(3))], START_CODES[2'($urandom_range(3))],
                     crc_t'($urandom_range(2)));
      default: send_random(PREAMBLE_OCTET, 8'($urandom), crc_t'($urandom_range(2)));
    endcase
  endtask

  // A fragmented frame: start, appends, final; now and then one link is broken.
  task automatic send_fragmented_frame();
    logic [1:0] s;
    logic [1:0] cnt;
    logic [7:0] lead;
    logic [7:0] smd;
    int         frags;
    bit         broken;
    crc_t       mode;
    s = 2'($urandom_range(3));
    cnt = LAST_COUNT_RESET;
    frags = $urandom_range(4);
    broken = 1'b0;
    send_random(PREAMBLE_OCTET, START_CODES[s], CRC_MERGE);
    for (int f = 0; f <= frags && !broken; f++) begin
      if ($urandom_range(9) == 0) send_bystander();
      cnt = cnt + 2'd1;
      lead = CONT_CODES[s];
      smd = START_CODES[cnt];
      if ($urandom_range(19) == 0) begin
        broken = 1'b1;
        if ($urandom_range(1)) lead = CONT_CODES[s + 2'd1];
        else smd = START_CODES[cnt + 2'd1];
      end
      if (f == frags) mode = $urandom_range(1) ? CRC_PLAIN : CRC_BAD;
      else mode = CRC_MERGE;
      send_random(lead, smd, mode);
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    lead_octet = '0;
    smd_octet = '0;
    data_length = '0;
    computed_crc = '0;
    rx_crc = '0;
    row_typed = 1'b0;
    row_expect = '{KIND_INVALID, CRC_BAD, DISP_IGNORE, 16'd0, 16'd0};
    gaps_on = 1'b1;

    // Express, verify, respond, malformed delimiters and an unfragmented start word.
    add_typed_row(PREAMBLE_OCTET, CODE_EXPRESS, 16'hffff, 32'h0, 32'h0,
                  KIND_EXPRESS, CRC_PLAIN, DISP_DELIVER, 16'd0, 16'hffff);
    add_typed_row(PREAMBLE_OCTET, CODE_EXPRESS, 16'd60, 32'hffffffff, 32'h0000ffff,
                  KIND_EXPRESS, CRC_MERGE, DISP_REJECT, 16'd0, 16'd0);
    add_typed_row(PREAMBLE_OCTET, CODE_EXPRESS, 16'd0, 32'h12345678, 32'h0,
                  KIND_EXPRESS, CRC_BAD, DISP_REJECT, 16'd0, 16'd0);
    add_typed_row(PREAMBLE_OCTET, CODE_VERIFY, 16'd60, 32'h0, 32'h0,
                  KIND_VERIFY, CRC_PLAIN, DISP_IGNORE, 16'd0, 16'd0);
    add_typed_row(PREAMBLE_OCTET, CODE_RESPOND, 16'd60, 32'h5, 32'h6,
                  KIND_RESPOND, CRC_BAD, DISP_IGNORE, 16'd0, 16'd0);
    add_typed_row(8'h00, 8'h00, 16'd0, 32'h0, 32'h0,
                  KIND_INVALID, CRC_PLAIN, DISP_REJECT, 16'd0, 16'd0);
    add_typed_row(8'hff, 8'hff, 16'hffff, 32'hffffffff, 32'hffffffff,
                  KIND_INVALID, CRC_PLAIN, DISP_REJECT, 16'd0, 16'd0);
    add_typed_row(PREAMBLE_OCTET, 8'h00, 16'd1, 32'h0, 32'h0,
                  KIND_INVALID, CRC_PLAIN, DISP_REJECT, 16'd0, 16'd0);
    add_typed_row(PREAMBLE_OCTET, START_CODES[0], 16'd100, 32'haaaa5555, 32'haaaa5555,
                  KIND_START, CRC_PLAIN, DISP_DELIVER, 16'd0, 16'd100);

    // A fragmented frame whose length saturates, closed by a plain CRC.
    add_typed_row(PREAMBLE_OCTET, START_CODES[1], 16'hfff0, 32'h0000abcd, 32'hffffabcd,
                  KIND_START, CRC_MERGE, DISP_START, 16'd0, 16'hfff0);
    add_row(CONT_CODES[1], START_CODES[0], 16'h0100, 32'h1, 32'hffff0001);
    add_row(CONT_CODES[1], START_CODES[1], 16'd5, 32'h2, 32'hffff0002);
    add_row(CONT_CODES[1], START_CODES[2], 16'd0, 32'h3, 32'h3);

    // Continuation words with no context, the wrong SMD-C or the wrong count.
    add_typed_row(CONT_CODES[0], START_CODES[0], 16'd64, 32'h0, 32'hffff0000,
                  KIND_CONT, CRC_MERGE, DISP_REJECT, 16'd0, 16'd0);
    add_row(PREAMBLE_OCTET, START_CODES[3], 16'd10, 32'h0, 32'hffff0000);
    add_row(CONT_CODES[0], START_CODES[0], 16'd10, 32'h0, 32'hffff0000);
    add_row(PREAMBLE_OCTET, START_CODES[2], 16'd0, 32'h0, 32'hffff0000);
    add_row(CONT_CODES[2], START_CODES[1], 16'd10, 32'h0, 32'hffff0000);

    // A clean frame ending in a bad CRC.
    add_row(PREAMBLE_OCTET, START_CODES[0], 16'd20, 32'h0, 32'hffff0000);
    add_row(CONT_CODES[0], START_CODES[0], 16'd30, 32'h0, 32'hffff0000);
    add_row(CONT_CODES[0], START_CODES[1], 16'd7, 32'h0, 32'h00000001);

    // Express and malformed words in the middle of a frame leave the context alone.
    add_row(PREAMBLE_OCTET, START_CODES[0], 16'd40, 32'h0, 32'hffff0000);
    add_row(PREAMBLE_OCTET, CODE_EXPRESS, 16'd64, 32'h0, 32'h0);
    add_row(CONT_CODES[0], 8'h00, 16'd1, 32'h0, 32'h0);
    add_row(CONT_CODES[0], START_CODES[0], 16'd50, 32'h9, 32'h9);
    add_typed_row(PREAMBLE_OCTET, START_CODES[3], 16'hffff, 32'h0, 32'h1,
                  KIND_START, CRC_BAD, DISP_REJECT, 16'd0, 16'd0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      put_word(directed_rows[i].lead, directed_rows[i].smd, directed_rows[i].len,
               directed_rows[i].calc, directed_rows[i].recv,
               directed_rows[i].typed, directed_rows[i].want);
    end

    // Random part: mostly well-formed fragmented frames, the rest noise.
    while (words_sent < TOTAL_WORDS) begin
      gaps_on = !(words_sent >= 600 && words_sent < 900);
      if ($urandom_range(99) < 70) send_fragmented_frame();
      else send_noise();
    end
    push = 1'b0;
    gaps_on = 1'b1;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("tb_preemption_mpacket_reassembly_tracker_unit OK");
    end else begin
      $display("tb_preemption_mpacket_reassembly_tracker_unit NOT OK");
    end
    $finish;
  end

endmodule
